/* rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
// Used by salc_store, salc_scan and set_assoc_lru_cache_sim.
`timescale 1ns / 1ps

package salc_pkg;

  localparam int TAG_W      = 64;
  localparam int AGE_W      = 32;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [2:0] SET_BITS_RESET   = 3'd4;
  localparam logic [3:0] WAYS_RESET       = 4'd1;
  localparam logic [3:0] BLOCK_BITS_RESET = 4'd4;

  // One cache line as held in the line store.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  // Outcome of a way scan.
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

/* rtl/salc_store.sv */
// Line store: one line per address, one read port with registered data, one write port.
// Runs a clearing pass over every address after reset. Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_store import salc_pkg::*; #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] rd_addr,
  output line_t             rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  line_t             wr_data,
  output logic              busy
);

  line_t             mem [DEPTH];
  logic [ADDR_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/salc_scan.sv */
// Way scan unit: one tag compare and two age compares, applied to one line per cycle while take is high.
// Tracks hit way, first free way, oldest valid way and the newest age. Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_scan import salc_pkg::*; #(
  parameter int WAY_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             take,
  input  logic [WAY_W-1:0] way,
  input  line_t            line,
  input  logic [TAG_W-1:0] blk,
  output scan_flags_t      flags,
  output logic [WAY_W-1:0] use_way,
  output logic [AGE_W-1:0] newest
);

  logic             hit_found;
  logic             free_found;
  logic             old_found;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] old_way;
  logic [AGE_W-1:0] old_age;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
      newest     <= '0;
    end else if (take) begin
      if (line.age > newest) begin
        newest <= line.age;
      end
      if (line.valid) begin
        if (!hit_found && line.tag == blk) begin
          hit_found <= 1'b1;
          hit_way   <= way;
        end
        // Strict compare keeps the lowest way among equal stamps.
        if (!old_found || line.age < old_age) begin
          old_found <= 1'b1;
          old_way   <= way;
          old_age   <= line.age;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_way   <= way;
      end
    end
  end

  always_comb begin
    flags.hit  = hit_found;
    flags.free = free_found;
    if (hit_found) begin
      use_way = hit_way;
    end else if (free_found) begin
      use_way = free_way;
    end else begin
      use_way = old_way;
    end
  end

endmodule

/* rtl/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU cache model: config registers, sequencer, counters.
// Instantiates salc_store and salc_scan; depends on salc_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_stall    opcode, address
//   out      source     out_valid / out_stall  hit, miss, eviction, store_hit, *_total
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// A request passes through the setup, scan and write states, and the next one is held
// off until the sequencer is idle again; the single store read port and the shared
// compare unit visit one way per cycle, up to the clamped ways_in_use.
// After reset the store is cleared one line a cycle (all (1 << MAX_SET_BITS) * MAX_WAYS
// lines, 512 by default) and in_stall stays high meanwhile.
// A new request is taken while a result waits under out_stall; the lookup then holds
// in its write step until the output register frees.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       opcode,
  input  logic [TAG_W-1:0]      address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic                  miss,
  output logic                  eviction,
  output logic                  store_hit,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      eviction_total,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int DEPTH  = SETS * MAX_WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);

  state_t state, state_next;

  logic [2:0]        set_bits;
  logic [3:0]        ways_in_use;
  logic [3:0]        block_bits;

  logic [OP_W-1:0]   op;
  logic [TAG_W-1:0]  blk;
  logic [ADDR_W-1:0] base;
  logic [NW_W-1:0]   rd_way;
  logic              pend;
  logic [WAY_W-1:0]  pend_way;

  logic [3:0]        sb_eff;
  logic [5:0]        ways_wide;
  logic [NW_W-1:0]   nw_eff;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_idx;
  logic              accept;
  logic              issue;
  logic              load_out;
  logic              store_busy;
  logic [ADDR_W-1:0] rd_addr;
  line_t             rd_line;
  line_t             wr_line;
  logic [ADDR_W-1:0] wr_addr;
  scan_flags_t       flags;
  logic [WAY_W-1:0]  use_way;
  logic [AGE_W-1:0]  newest;
  logic              res_hit;
  logic              res_miss;
  logic              res_evict;
  logic              res_store_hit;

  // Geometry, clamped to what the store holds.
  always_comb begin
    sb_eff = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
    ways_wide = {2'b00, ways_in_use};
    if (ways_wide == 6'd0) begin
      nw_eff = NW_W'(1);
    end else if (ways_wide > 6'(MAX_WAYS)) begin
      nw_eff = NW_W'(MAX_WAYS);
    end else begin
      nw_eff = NW_W'(ways_wide);
    end
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (4'(i) < sb_eff);
    end
    set_idx = blk[SET_W-1:0] & set_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RESET;
      ways_in_use <= WAYS_RESET;
      block_bits  <= BLOCK_BITS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_BITS:   set_bits    <= cfg_data[2:0];
        CFG_WAYS:       ways_in_use <= cfg_data;
        CFG_BLOCK_BITS: block_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE) || store_busy;
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == ST_SCAN) && (rd_way < nw_eff);
  assign load_out = (state == ST_WRITE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !pend) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Request capture and way sequencing.
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= opcode;
      blk <= address >> block_bits;
    end
    if (state == ST_SETUP) begin
      base <= ADDR_W'(set_idx) * ADDR_W'(MAX_WAYS);
    end
    pend_way <= rd_way[WAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_way <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= issue;
      if (state == ST_SETUP) begin
        rd_way <= '0;
      end else if (issue) begin
        rd_way <= rd_way + 1'b1;
      end
    end
  end

  assign rd_addr = base + ADDR_W'(rd_way[WAY_W-1:0]);

  salc_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_line),
    .wr_en   (load_out),
    .wr_addr (wr_addr),
    .wr_data (wr_line),
    .busy    (store_busy)
  );

  salc_scan #(
    .WAY_W (WAY_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_SETUP),
    .take    (pend),
    .way     (pend_way),
    .line    (rd_line),
    .blk     (blk),
    .flags   (flags),
    .use_way (use_way),
    .newest  (newest)
  );

  // On a hit the stored tag already equals blk, so the full line can be rewritten.
  always_comb begin
    wr_addr       = base + ADDR_W'(use_way);
    wr_line.valid = 1'b1;
    wr_line.tag   = blk;
    wr_line.age   = newest + 1'b1;
    res_hit       = flags.hit;
    res_miss      = !flags.hit;
    res_evict     = !flags.hit && !flags.free;
    res_store_hit = (op == OP_MODIFY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else if (load_out) begin
      out_valid      <= 1'b1;
      hit_total      <= hit_total + CNT_W'(res_hit) + CNT_W'(res_store_hit);
      miss_total     <= miss_total + CNT_W'(res_miss);
      eviction_total <= eviction_total + CNT_W'(res_evict);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit       <= res_hit;
      miss      <= res_miss;
      eviction  <= res_evict;
      store_hit <= res_store_hit;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> in_stall)
    else $error("request accepted during store clearing");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((hit ^ miss) && (!eviction || miss)))
    else $error("inconsistent hit, miss and eviction flags");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_way <= nw_eff))
    else $error("way counter ran past the ways in use");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (miss_total == $past(miss_total) + CNT_W'(miss)))
    else $error("miss counter out of step with the result");

endmodule

/* bench/tb_set_assoc_lru_cache_sim.sv */
// Testbench for set_assoc_lru_cache_sim: directed and random accesses, checked against
// a line-by-line LRU shadow of the cache kept here. Depends on salc_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;
  import salc_pkg::*;

  localparam int N_SET_BITS_MAX = 6;
  localparam int N_WAYS_MAX     = 8;
  localparam int N_LINES        = (1 << N_SET_BITS_MAX) * N_WAYS_MAX;
  localparam int RANDOM_ITEMS   = 800;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_PRINTED    = 40;

  // Opcode 3 has no package name; the block treats it as a load.
  localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
  // Register index 3 is not decoded.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             eviction;
    logic             store_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } access_outcome_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       opcode    = OP_LOAD;
  logic [TAG_W-1:0]      address   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic                  miss;
  logic                  eviction;
  logic                  store_hit;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      eviction_total;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow copy of the cache lines, counters and geometry registers.
  logic             line_valid [N_LINES];
  logic [TAG_W-1:0] line_tag   [N_LINES];
  logic [AGE_W-1:0] line_age   [N_LINES];
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] evict_count;
  logic [2:0]       geo_set_bits;
  logic [3:0]       geo_ways;
  logic [3:0]       geo_block_bits;

  access_outcome_t pending_outcomes[$];
  access_outcome_t oldest_outcome;
  int unsigned     mismatch_count = 0;
  int unsigned     out_hold_left  = 0;
  bit              no_idle        = 1'b0;

  set_assoc_lru_cache_sim #(
    .MAX_SET_BITS(N_SET_BITS_MAX),
    .MAX_WAYS    (N_WAYS_MAX)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .address       (address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .miss          (miss),
    .eviction      (eviction),
    .store_hit     (store_hit),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic int eff_set_bits();
    return (geo_set_bits > N_SET_BITS_MAX) ? N_SET_BITS_MAX : int'(geo_set_bits);
  endfunction

  function automatic int eff_ways();
    if (geo_ways == 0) begin
      return 1;
    end
    return (geo_ways > N_WAYS_MAX) ? N_WAYS_MAX : int'(geo_ways);
  endfunction

  task automatic clear_shadow();
    foreach (line_valid[k]) begin
      line_valid[k] = 1'b0;
      line_tag[k]   = '0;
      line_age[k]   = '0;
    end
    hit_count      = '0;
    miss_count     = '0;
    evict_count    = '0;
    geo_set_bits   = SET_BITS_RESET;
    geo_ways       = WAYS_RESET;
    geo_block_bits = BLOCK_BITS_RESET;
  endtask

  // Looks the access up in the shadow, updates lines, ages and counters, and
  // returns the outcome the block must report for it.
  function automatic access_outcome_t predict_access(input logic [OP_W-1:0] op,
                                                     input logic [TAG_W-1:0] addr);
    access_outcome_t  res;
    logic [TAG_W-1:0] blk;
    logic [AGE_W-1:0] newest;
    logic [AGE_W-1:0] old_age;
    int               nw;
    int               base;
    int               used;
    int               hit_way;
    int               free_way;
    int               old_way;
    nw       = eff_ways();
    blk      = addr >> geo_block_bits;
    base     = int'(blk & ((64'd1 << eff_set_bits()) - 64'd1)) * N_WAYS_MAX;
    newest   = '0;
    old_age  = '0;
    hit_way  = -1;
    free_way = -1;
    old_way  = -1;
    used     = 0;
    for (int w = 0; w < nw; w++) begin
      if (line_age[base + w] > newest) begin
        newest = line_age[base + w];
      end
      if (line_valid[base + w]) begin
        if (hit_way < 0 && line_tag[base + w] == blk) begin
          hit_way = w;
        end
        // Strict compare keeps the lowest way among equal ages.
        if (old_way < 0 || line_age[base + w] < old_age) begin
          old_way = w;
          old_age = line_age[base + w];
        end
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res = '0;
    if (hit_way >= 0) begin
      res.hit = 1'b1;
      used    = hit_way;
    end else begin
      res.miss = 1'b1;
      if (free_way >= 0) begin
        used = free_way;
      end else begin
        res.eviction = 1'b1;
        used         = old_way;
      end
      line_valid[base + used] = 1'b1;
      line_tag[base + used]   = blk;
    end
    line_age[base + used] = newest + 1'b1;
    res.store_hit = (op == OP_MODIFY);
    hit_count   = hit_count + res.hit + res.store_hit;
    miss_count  = miss_count + res.miss;
    evict_count = evict_count + res.eviction;
    res.hit_total      = hit_count;
    res.miss_total     = miss_count;
    res.eviction_total = evict_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // Result side: check every accepted result and draw a stall after each one.
  always @(posedge clk) begin
    if (rst) begin
      out_hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no request outstanding", 64'd0, 64'd0);
        end else begin
          oldest_outcome = pending_outcomes.pop_front();
          if (hit !== oldest_outcome.hit)
            report_mismatch("hit", 64'(hit), 64'(oldest_outcome.hit));
          if (miss !== oldest_outcome.miss)
            report_mismatch("miss", 64'(miss), 64'(oldest_outcome.miss));
          if (eviction !== oldest_outcome.eviction)
            report_mismatch("eviction", 64'(eviction), 64'(oldest_outcome.eviction));
          if (store_hit !== oldest_outcome.store_hit)
            report_mismatch("store_hit", 64'(store_hit), 64'(oldest_outcome.store_hit));
          if (hit_total !== oldest_outcome.hit_total)
            report_mismatch("hit_total", 64'(hit_total), 64'(oldest_outcome.hit_total));
          if (miss_total !== oldest_outcome.miss_total)
            report_mismatch("miss_total", 64'(miss_total), 64'(oldest_outcome.miss_total));
          if (eviction_total !== oldest_outcome.eviction_total)
            report_mismatch("eviction_total", 64'(eviction_total),
                            64'(oldest_outcome.eviction_total));
        end
        out_hold_left = draw_wait();
      end else if (out_hold_left > 0) begin
        out_hold_left--;
      end
      out_stall <= (out_hold_left > 0);
    end
  end

  // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_access(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] addr);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    address  <= addr;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(predict_access(op, addr));
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SET_BITS:   geo_set_bits   = val[2:0];
      CFG_WAYS:       geo_ways       = val;
      CFG_BLOCK_BITS: geo_block_bits = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [3:0] sb, input logic [3:0] ways,
                              input logic [3:0] bb);
    settle();
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_WAYS, ways);
    write_reg(CFG_BLOCK_BITS, bb);
    cfg_write <= 1'b0;
  endtask

  // Reset geometry: 16 sets, direct mapped, 16-byte blocks; opcode 3 acts as a load.
  task automatic test_reset_geometry();
    send_access(OP_LOAD, 64'h0);
    send_access(OP_STORE, 64'h8);
    send_access(OP_MODIFY, 64'h0);
    send_access(OP_LOAD, 64'h100);
    send_access(OP_UNUSED, 64'h104);
  endtask

  // Shrinking to one way and growing back leaves two ways of set 5 with equal
  // ages; the lower way must be the one replaced.
  task automatic test_tied_ages();
    set_geometry(4'd6, 4'd2, 4'd0);
    send_access(OP_LOAD, 64'h105);
    send_access(OP_LOAD, 64'h205);
    set_geometry(4'd6, 4'd1, 4'd0);
    send_access(OP_STORE, 64'h305);
    set_geometry(4'd6, 4'd2, 4'd0);
    send_access(OP_LOAD, 64'h405);
    send_access(OP_LOAD, 64'h205);
    send_access(OP_LOAD, 64'h305);
  endtask

  task automatic test_field_extremes();
    set_geometry(4'd6, 4'd8, 4'd0);
    send_access(OP_LOAD, '1);
    send_access(OP_STORE, 64'h0);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
    send_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(OP_UNUSED, 64'h5555_5555_5555_5555);
    send_access(OP_LOAD, '1);
    // Out-of-range register values: sets and ways clamp, block size is taken as is.
    set_geometry(4'hF, 4'hF, 4'hF);
    send_access(OP_LOAD, '1);
    send_access(OP_MODIFY, 64'h7FFF);
    // Zero ways behaves as one way, with a single set and 1-byte blocks.
    set_geometry(4'd0, 4'd0, 4'd0);
    send_access(OP_LOAD, 64'h1);
    send_access(OP_STORE, 64'h1);
  endtask

  // Lines survive a geometry change and are looked up with the new mapping.
  task automatic test_geometry_change();
    set_geometry(4'd2, 4'd4, 4'd4);
    send_access(OP_LOAD, 64'h40);
    send_access(OP_LOAD, 64'h80);
    settle();
    write_reg(CFG_SET_BITS, 4'd3);
    write_reg(CFG_NONE, 4'hF);
    cfg_write <= 1'b0;
    send_access(OP_LOAD, 64'h40);
    send_access(OP_MODIFY, 64'h80);
  endtask

  // Each phase picks a geometry and hammers a few sets with slightly more blocks
  // than they hold, mixed with fully random addresses.
  task automatic test_random_traffic();
    int unsigned    sent;
    int unsigned    phase;
    int unsigned    run_len;
    int unsigned    hot_set [4];
    logic [3:0]     sb_d;
    logic [3:0]     ways_d;
    logic [3:0]     bb_d;
    logic [31:0]    blk;
    logic [63:0]    hi_base;
    logic [63:0]    addr;
    logic [OP_W-1:0] op;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          sb_d = 4'd0; ways_d = 4'd1; bb_d = 4'd0;
        end
        1: begin
          sb_d = 4'd6; ways_d = 4'd8; bb_d = 4'd12;
        end
        2: begin
          sb_d = 4'd1; ways_d = 4'd8; bb_d = 4'd15;
        end
        default: begin
          sb_d   = 4'($urandom_range(0, 15));
          ways_d = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(0, 15));
          bb_d   = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(0, 15));
        end
      endcase
      set_geometry(sb_d, ways_d, bb_d);
      no_idle = ($urandom_range(0, 3) == 0);
      hi_base = {$urandom, 32'd0};
      foreach (hot_set[i]) begin
        hot_set[i] = $urandom_range(0, (1 << eff_set_bits()) - 1);
      end
      run_len = $urandom_range(25, 60);
      for (int n = 0; n < run_len && sent < RANDOM_ITEMS; n++) begin
        op = OP_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          blk  = ($urandom_range(0, eff_ways() + 1) << eff_set_bits())
                 | hot_set[$urandom_range(0, 3)];
          addr = hi_base + ({32'd0, blk} << geo_block_bits)
                 + ($urandom & ((32'd1 << geo_block_bits) - 32'd1));
        end
        send_access(op, addr);
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The line store is cleared after reset with requests held off.
    do @(posedge clk); while (in_stall);
    test_reset_geometry();
    test_tied_ages();
    test_field_extremes();
    test_geometry_change();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
